[hdl/lcgr_pkg.sv]
// Package for the ranged linear congruential random source.
// Holds the generator constants, command codes and shared widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcgr_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned MulBW = 18;

	localparam logic [WordW-1:0] LCG_MUL    = 32'd214013;
	localparam logic [WordW-1:0] LCG_ADD    = 32'd2531011;
	localparam logic [WordW-1:0] SEED_RESET = 32'h1234_5678;
	localparam logic [WordW-1:0] BYTE_RANGE = 32'd255;

	localparam logic [1:0] CMD_DRAW   = 2'd0;
	localparam logic [1:0] CMD_MIX    = 2'd1;
	localparam logic [1:0] CMD_PACKED = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	typedef logic [WordW-1:0] word_t;

endpackage

`default_nettype wire

[hdl/lcgr_rem.sv]
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on lcgr_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module lcgr_rem
	import lcgr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  word_t       dividend,
	input  word_t       divisor,
	output logic        done,
	output word_t       rem
);

	localparam int unsigned CntW = $clog2(WordW);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	word_t             dvd_q;
	word_t             dsr_q;
	word_t             rem_q;
	logic [WordW:0]    trial;
	logic [WordW:0]    shifted;

	// Shift in the next dividend bit and try to take the divisor away.
	assign shifted = {rem_q, dvd_q[WordW-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WordW-2:0], 1'b0};
			if (!trial[WordW])
				rem_q <= trial[WordW-1:0];
			else
				rem_q <= shifted[WordW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[hdl/lcg_ranged_random.sv]
// Top level of the ranged linear congruential random source.
// Depends on lcgr_pkg and instantiates the remainder unit lcgr_rem.
//
//   Channel   Dir  Handshake                     Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tuser: command; tdata: range, entropy
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: value
//
// A mix or an undefined command goes straight to the output step, a draw with a
// range below 65536 is scaled by the shared multiplier, a packed-word draw makes
// four byte draws, and a draw with a larger range goes to the bit-serial remainder unit.
// The input side is ready only while the sequencer is idle; one item is
// worked on at a time.
// The result sits in an output register, so the next item is taken while a
// result still waits for the downstream side.
// Reset is asynchronous and active low; it loads the seed with its start value.
`timescale 1ns / 1ps
`default_nettype none

module lcg_ranged_random
	import lcgr_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [63:0]  s_axis_tdata,   // [31:0] range, [63:32] entropy
	input  wire  [1:0]   s_axis_tuser,   // [1:0] command
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [31:0]  m_axis_tdata    // [31:0] value
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SEED  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_SCL2  = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_PUT   = 3'd6;

	logic [2:0]              state_q;
	logic [1:0]              cmd_q;
	word_t                   range_q;
	word_t                   seed_q;
	word_t                   result_q;
	word_t                   prod_q;
	logic [1:0]              cnt_q;
	logic                    out_valid_q;
	word_t                   out_data_q;

	word_t                   mul_a;
	logic [MulBW-1:0]        mul_b;
	logic [WordW+MulBW-1:0]  mul_full;
	word_t                   seed_next;
	logic                    accept;
	logic                    put_fire;
	logic                    div_start;
	logic                    div_done;
	word_t                   div_rem;
	logic                    draw_valid;
	word_t                   draw;
	logic [7:0]              draw_byte;

	assign accept = s_axis_tvalid && s_axis_tready;

	// The finished result moves into the output register once that is free.
	assign put_fire = (state_q == ST_PUT) && (!out_valid_q || m_axis_tready);

	// The one multiplier serves both the seed update (seed times the LCG
	// multiplier) and the small-range scaling (top half of seed times range).
	// Its product is registered before anyone uses it.
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = {16'd0, seed_q[WordW-1:16]};
			mul_b = {2'b00, range_q[15:0]};
		end else begin
			mul_a = seed_q;
			mul_b = LCG_MUL[MulBW-1:0];
		end
	end

	assign mul_full  = mul_a * mul_b;
	assign seed_next = prod_q + LCG_ADD;

	always_ff @(posedge clk) begin
		prod_q <= mul_full[WordW-1:0];
	end

	// A range of 65536 or more goes to the remainder unit with the new seed.
	assign div_start = (state_q == ST_UPD) && (range_q[WordW-1:16] != 16'd0);

	lcgr_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (seed_next),
		.divisor  (range_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// One reduced draw is ready either from the scaled product or from the
	// remainder unit. A small range leaves the high half of the product.
	always_comb begin
		draw_valid = 1'b0;
		draw       = '0;
		if (state_q == ST_SCL2) begin
			draw_valid = 1'b1;
			draw       = {16'd0, prod_q[WordW-1:16]};
		end else if ((state_q == ST_DIV) && div_done) begin
			draw_valid = 1'b1;
			draw       = div_rem;
		end
	end

	// Packed draws are below 255, so adding one never wraps the byte.
	assign draw_byte = draw[7:0] + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= SEED_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_fire)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						unique case (s_axis_tuser) inside
							CMD_DRAW, CMD_PACKED: state_q <= ST_SEED;
							CMD_MIX: begin
								seed_q  <= seed_q ^ s_axis_tdata[63:32];
								state_q <= ST_PUT;
							end
							CMD_NONE: state_q <= ST_PUT;
							default: state_q <= ST_PUT;
						endcase
					end
				end
				ST_SEED: state_q <= ST_UPD;
				ST_UPD: begin
					seed_q  <= seed_next;
					state_q <= div_start ? ST_DIV : ST_SCALE;
				end
				ST_SCALE: state_q <= ST_SCL2;
				ST_SCL2, ST_DIV: begin
					if (draw_valid) begin
						if ((cmd_q == CMD_PACKED) && (cnt_q != 2'd3)) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					if (put_fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and result accumulation.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_axis_tuser;
			range_q  <= (s_axis_tuser == CMD_PACKED) ? BYTE_RANGE : s_axis_tdata[31:0];
			result_q <= '0;
		end else if (draw_valid) begin
			if (cmd_q == CMD_PACKED)
				result_q <= {result_q[23:0], draw_byte};
			else
				result_q <= draw;
		end
		if (put_fire)
			out_data_q <= result_q;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[hdl/lcgr_chk.sv]
// Port-level checker for lcg_ranged_random, bound to the top level.
// Depends on lcgr_pkg for the command codes.
`timescale 1ns / 1ps
`default_nettype none

module lcgr_chk
	import lcgr_pkg::*;
(
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire [63:0]  s_axis_tdata,
	input wire [1:0]   s_axis_tuser,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [31:0]  m_axis_tdata
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// A result held back by the consumer stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every accepted item keeps the input side busy in the cycle that follows.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("input ready straight after an accepted item");

	// Ready drops only because an item was taken.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("input ready fell without an item");

	// A mix taken while the output register is free answers zero through the put state and the output register.
	a_mix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_axis_tuser == CMD_MIX) && (!m_axis_tvalid || m_axis_tready)
		|=> ##1 m_axis_tvalid && (m_axis_tdata == 32'd0))
		else $error("mix did not answer zero in time");

endmodule

bind lcg_ranged_random lcgr_chk u_lcgr_chk (.*);

`default_nettype wire

[verif/lcg_ranged_random_tb.sv]
// Self-checking testbench for lcg_ranged_random.
// Depends on lcgr_pkg and the lcg_ranged_random top level; a local seed model predicts every value.
`timescale 1ns / 1ps

module lcg_ranged_random_tb;
	import lcgr_pkg::*;

	localparam word_t SMALL_BOUND = 32'd65536;
	localparam int    NUM_RANDOM  = 500;
	localparam int    QUIET_TAIL  = 60;
	localparam int    STALL_LIMIT = 3000;
	localparam int    LONG_HOLD   = 400;
	localparam int    HOLD_AT     = 120;
	localparam int    SETTLE_WAIT = 60;

	typedef struct {
		logic [1:0] cmd;
		word_t      bound;
		word_t      entropy;
		bit         settle;   // sender waits for every result before offering this item
	} rng_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;

	rng_item_t pending_items[$];
	word_t     expected_values[$];
	rng_item_t cur_item;
	bit        offering;
	int        send_gap;
	int        recv_stall;
	int        recv_hold;
	bit        hold_done;
	int        results_seen;
	int        mismatches;
	int        failures;
	int        idle_cycles;
	word_t     gen_seed;

	lcg_ranged_random u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Advances the seed and reduces it to [0, bound), or to zero for a bound of zero.
	function automatic word_t next_draw(input word_t bound);
		logic [63:0] prod;
		gen_seed = gen_seed * LCG_MUL + LCG_ADD;
		if (bound >= SMALL_BOUND) begin
			return gen_seed % bound;
		end
		prod = {48'd0, gen_seed[31:16]} * {32'd0, bound};
		return prod[47:16];
	endfunction

	function automatic word_t predict_value(input rng_item_t it);
		word_t v;
		word_t b;
		v = '0;
		case (it.cmd)
			CMD_DRAW: begin
				v = next_draw(it.bound);
			end
			CMD_MIX: begin
				gen_seed = gen_seed ^ it.entropy;
			end
			CMD_PACKED: begin
				// First draw ends up in the top byte.
				for (int k = 0; k < 4; k++) begin
					b = next_draw(BYTE_RANGE) + 32'd1;
					v = {v[23:0], b[7:0]};
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic push_item(input logic [1:0] cmd, input word_t bound, input word_t entropy);
		rng_item_t it;
		it.cmd = cmd;
		it.bound = bound;
		it.entropy = entropy;
		it.settle = 1'b0;
		pending_items.push_back(it);
	endtask

	// Sender: presents one item at a time, idles in bursts, and predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offering = 1'b0;
			send_gap = 0;
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_values.push_back(predict_value(cur_item));
				offering = 1'b0;
				if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
					send_gap = $urandom_range(1, 14);
				end
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					if (!pending_items[0].settle || expected_values.size() == 0) begin
						cur_item = pending_items.pop_front();
						offering = 1'b1;
					end
				end
			end
			s_axis_tvalid <= offering;
			s_axis_tdata  <= {cur_item.entropy, cur_item.bound};
			s_axis_tuser  <= cur_item.cmd;
		end
	end

	// Receiver: checks each result against the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_stall = 0;
			recv_hold = 0;
			hold_done = 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_values.size() == 0) begin
					failures++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: actual %08h", m_axis_tdata);
					end
				end else begin
					if (m_axis_tdata !== expected_values[0]) begin
						failures++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("value mismatch: expected %08h actual %08h",
								expected_values[0], m_axis_tdata);
						end
					end
					void'(expected_values.pop_front());
				end
				if (!hold_done && results_seen == HOLD_AT) begin
					// Long back-pressure so the output register fills and the input stalls.
					hold_done = 1'b1;
					recv_hold = LONG_HOLD;
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
					recv_stall = $urandom_range(1, 14);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		word_t bound;
		int    c;
		gen_seed = SEED_RESET;
		results_seen = 0;
		mismatches = 0;
		failures = 0;
		idle_cycles = 0;
		cur_item = '{CMD_DRAW, '0, '0, 1'b0};

		// Directed part: range edges, every command, ignored fields, undefined command.
		push_item(CMD_DRAW, 32'd0, 32'd0);
		push_item(CMD_DRAW, 32'd1, 32'hFFFF_FFFF);
		push_item(CMD_DRAW, 32'd2, 32'd0);
		push_item(CMD_DRAW, 32'd255, 32'd0);
		push_item(CMD_DRAW, 32'd65535, 32'd0);
		push_item(CMD_DRAW, 32'd65536, 32'd0);
		push_item(CMD_DRAW, 32'd65537, 32'd0);
		push_item(CMD_DRAW, 32'h8000_0000, 32'd0);
		push_item(CMD_DRAW, 32'hFFFF_FFFF, 32'd0);
		push_item(CMD_PACKED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_PACKED, 32'd0, 32'd0);
		push_item(CMD_MIX, 32'hFFFF_FFFF, 32'd0);
		pending_items[$].settle = 1'b1;
		push_item(CMD_DRAW, 32'd1000, 32'd0);
		push_item(CMD_MIX, 32'd0, 32'hFFFF_FFFF);
		push_item(CMD_DRAW, 32'hFFFF_FFFF, 32'd0);
		push_item(CMD_MIX, 32'd12345, 32'hA5A5_5A5A);
		push_item(CMD_PACKED, 32'd7, 32'd0);
		push_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_NONE, 32'd0, 32'd0);
		push_item(CMD_DRAW, 32'd0, 32'hFFFF_FFFF);
		push_item(CMD_DRAW, 32'd40000, 32'd0);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			case ($urandom_range(0, 9)) inside
				0, 1, 2, 3, 4: bound = $urandom_range(0, 65535);
				5, 6:          bound = $urandom;
				7: begin
					case ($urandom_range(0, 4))
						0:       bound = 32'd0;
						1:       bound = 32'd1;
						2:       bound = 32'd65535;
						3:       bound = 32'd65536;
						default: bound = 32'hFFFF_FFFF;
					endcase
				end
				default:       bound = $urandom >> $urandom_range(0, 31);
			endcase
			c = $urandom_range(0, 19);
			if (c < 10) begin
				push_item(CMD_DRAW, bound, $urandom);
			end else if (c < 13) begin
				push_item(CMD_MIX, bound, $urandom);
			end else if (c < 18) begin
				push_item(CMD_PACKED, bound, $urandom);
			end else begin
				push_item(CMD_NONE, bound, $urandom);
			end
			if (n == NUM_RANDOM / 2) begin
				pending_items[$].settle = 1'b1;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || offering || expected_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);

		if (failures == 0 && expected_values.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
